@@ hdl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
package skt_pkg;

  localparam int unsigned KEY_W    = 12;
  localparam int unsigned WT_W     = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TOTAL_W  = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DROP   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } dp_cmd_t;

endpackage

@@ hdl/skt_ctrl.sv @@
// Controller state machine that sequences one word through the table.
module skt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output skt_pkg::dp_cmd_t cmd_o
);
  import skt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CMP;
      end
      S_CMP: state_d = S_UPD;
      S_UPD: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.update  = (state_q == S_UPD);

endmodule

@@ hdl/skt_dp.sv @@
// Datapath: a row of sorted cells with per-cell comparators, count, total and result register.
module skt_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  skt_pkg::dp_cmd_t              cmd_i,
  input  logic                          opcode_i,
  input  logic [1:0]                    key_class_i,
  input  logic [9:0]                    key_number_i,
  input  logic [skt_pkg::WT_W-1:0]      weight_i,
  output logic [skt_pkg::STATUS_W-1:0]  status_o,
  output logic [skt_pkg::COUNT_W-1:0]   entry_count_o,
  output logic [skt_pkg::TOTAL_W-1:0]   weight_total_o
);
  import skt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TotW = $clog2(TABLE_DEPTH * 15 + 1);

  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [WT_W-1:0]     wt_q;

  logic [KEY_W-1:0]    cell_key_q [TABLE_DEPTH];
  logic [WT_W-1:0]     cell_wt_q  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_q, eq_q, lt_d, eq_d;

  logic [CntW-1:0]     count_q, count_d;
  logic [TotW-1:0]     total_q, total_d;

  logic [STATUS_W-1:0] status_q;
  status_e             status_d;
  logic [COUNT_W-1:0]  count_out_q;
  logic [TOTAL_W-1:0]  total_out_q;

  logic                hit;
  logic                full;
  logic [WT_W-1:0]     hit_wt;
  logic                do_ins, do_drop;

  logic [CntW+COUNT_W-1:0] count_wide;
  logic [TotW+TOTAL_W-1:0] total_wide;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= {key_class_i, key_number_i};
      wt_q  <= weight_i;
    end
  end

  // Only cells below the fill count take part in the compare.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
    logic cell_valid;
    assign cell_valid = (count_q > CntW'(i));
    assign lt_d[i] = cell_valid && (cell_key_q[i] < key_q);
    assign eq_d[i] = cell_valid && (cell_key_q[i] == key_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_comb begin
    hit_wt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_wt = hit_wt | (eq_q[i] ? cell_wt_q[i] : '0);
    end
  end

  assign hit     = |eq_q;
  assign full    = (count_q == CntW'(TABLE_DEPTH));
  assign do_ins  = cmd_i.update && (op_q == OP_INSERT) && !hit && !full;
  assign do_drop = cmd_i.update && (op_q == OP_DROP) && hit;

  // Since the row is sorted, the less-than flags form a prefix, so each cell
  // decides its next contents from its own flag and its neighbor's.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] nkey;
    logic [WT_W-1:0]  nwt;
    always_comb begin
      nkey = cell_key_q[i];
      nwt  = cell_wt_q[i];
      if (do_ins && !lt_q[i]) begin
        if (i == 0) begin
          nkey = key_q;
          nwt  = wt_q;
        end else if (lt_q[(i == 0) ? 0 : i-1]) begin
          nkey = key_q;
          nwt  = wt_q;
        end else begin
          nkey = cell_key_q[(i == 0) ? 0 : i-1];
          nwt  = cell_wt_q[(i == 0) ? 0 : i-1];
        end
      end else if (do_drop && !lt_q[i] && (i < TABLE_DEPTH - 1)) begin
        nkey = cell_key_q[(i < TABLE_DEPTH - 1) ? i+1 : i];
        nwt  = cell_wt_q[(i < TABLE_DEPTH - 1) ? i+1 : i];
      end
    end
    always_ff @(posedge clk_i) begin
      cell_key_q[i] <= nkey;
      cell_wt_q[i]  <= nwt;
    end
  end

  always_comb begin
    count_d  = count_q;
    total_d  = total_q;
    status_d = ST_INSERTED;
    if (op_q == OP_INSERT) begin
      if (hit) begin
        status_d = ST_DUPLICATE;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_INSERTED;
        count_d  = count_q + CntW'(1);
        total_d  = total_q + TotW'(wt_q);
      end
    end else begin
      if (hit) begin
        status_d = ST_DROPPED;
        count_d  = count_q - CntW'(1);
        total_d  = (total_q >= TotW'(hit_wt)) ? total_q - TotW'(hit_wt) : '0;
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, count_d};
  assign total_wide = {{TOTAL_W{1'b0}}, total_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else if (cmd_i.update) begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // The reported total saturates; the count is reported modulo 32.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      status_q    <= status_d;
      count_out_q <= count_wide[COUNT_W-1:0];
      total_out_q <= (total_wide > (TotW+TOTAL_W)'(255)) ? 8'hFF
                                                         : total_wide[TOTAL_W-1:0];
    end
  end

  assign status_o       = status_q;
  assign entry_count_o  = count_out_q;
  assign weight_total_o = total_out_q;

endmodule

@@ hdl/sorted_key_table_with_sum.sv @@
// Top level of the sorted key table with running weight total.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i, in_stall_o | opcode_i, key_class_i, key_number_i, weight_i
//  out     | output    | out_valid_o, out_stall_i | status_o, entry_count_o, weight_total_o
//
// A word passes through load, a compare of every cell against the key in parallel,
// then the shift of the cell row and count update before its result is valid.
// The next word can be accepted at the earliest in the cycle after the result is taken;
// the compare flags are registered between the compare and the update.
// Reset clears the count and total at once; cell contents need no clearing.
// While the result is stalled the block holds it and accepts no input.
module sorted_key_table_with_sum #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [1:0]  key_class_i,
  input  logic [9:0]  key_number_i,
  input  logic [3:0]  weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  entry_count_o,
  output logic [7:0]  weight_total_o
);
  import skt_pkg::*;

  dp_cmd_t cmd;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  skt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .key_class_i    (key_class_i),
    .key_number_i   (key_number_i),
    .weight_i       (weight_i),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .weight_total_o (weight_total_o)
  );

endmodule
